// ===== src/radar_measurement_jacobian_macros.svh =====
// Assertion helpers shared by the radar Jacobian RTL.
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RMJ_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rmj assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RMJ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rmj assertion failed");

`endif

// ===== src/rmj_pkg.sv =====
`timescale 1ns / 1ps

package rmj_pkg;

  localparam int FracW     = 16;
  localparam int CfgW      = 16;
  localparam int IdxW      = 8;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;

  localparam logic [IdxW-1:0] RegThreshold = 8'd0;
  localparam logic [IdxW-1:0] RegFloor     = 8'd1;

  localparam logic [CfgW-1:0] ThresholdReset = 16'd7;
  localparam logic [CfgW-1:0] FloorReset     = 16'd66;

  // Fields that ride alongside the square root pipeline
  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic        nx;
    logic        ny;
    logic        nd;
    logic        clamp;
    logic [63:0] sq;
    logic [63:0] md;
  } side_t;

  // Fields that ride alongside the dividers
  typedef struct packed {
    logic valid;
    logic nx;
    logic ny;
    logic nd;
    logic clamp;
  } tail_t;

  // Output beat: tdata plus the clamp flag
  typedef struct packed {
    logic         clamp;
    logic [191:0] data;
  } beat_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Saturate a magnitude to the signed 32-bit range of its sign
  function automatic logic [31:0] clamp_mag(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    return (m > lim) ? lim[31:0] : m[31:0];
  endfunction

  function automatic logic [31:0] to_bits(input logic neg, input logic [31:0] m);
    return neg ? (32'd0 - m) : m;
  endfunction

  // Divider result as a wide magnitude; overflow reads as all ones
  function automatic logic [63:0] div_mag(input logic ovf, input logic [31:0] q);
    return ovf ? '1 : {32'd0, q};
  endfunction

endpackage

// ===== src/rmj_sqrt.sv =====
`timescale 1ns / 1ps

// Integer square root of side.sq, one result bit per stage.
module rmj_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  rmj_pkg::side_t in_side,
  output logic           out_valid,
  output rmj_pkg::side_t out_side,
  output logic [31:0]    out_root
);

  logic           vld_q  [rmj_pkg::SqrtSteps];
  logic [63:0]    val_q  [rmj_pkg::SqrtSteps];
  logic [63:0]    res_q  [rmj_pkg::SqrtSteps];
  rmj_pkg::side_t side_q [rmj_pkg::SqrtSteps];

  for (genvar k = 0; k < rmj_pkg::SqrtSteps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0]    pv, pr, trial, nv, nr;
    logic           pval;
    rmj_pkg::side_t ps;

    if (k == 0) begin : g_first
      assign pv   = in_side.sq;
      assign pr   = '0;
      assign pval = in_valid;
      assign ps   = in_side;
    end else begin : g_rest
      assign pv   = val_q[k-1];
      assign pr   = res_q[k-1];
      assign pval = vld_q[k-1];
      assign ps   = side_q[k-1];
    end

    // one restoring step
    always_comb begin
      trial = pr + Bit;
      if (pv >= trial) begin
        nv = pv - trial;
        nr = (pr >> 1) + Bit;
      end else begin
        nv = pv;
        nr = pr >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= pval;
      end
      if (en) begin
        val_q[k]  <= nv;
        res_q[k]  <= nr;
        side_q[k] <= ps;
      end
    end
  end

  assign out_valid = vld_q[rmj_pkg::SqrtSteps-1];
  assign out_side  = side_q[rmj_pkg::SqrtSteps-1];
  assign out_root  = res_q[rmj_pkg::SqrtSteps-1][31:0];

endmodule

// ===== src/rmj_div.sv =====
`timescale 1ns / 1ps

// Pipelined 64/64 restoring divider with a 32-bit quotient and overflow flag.
module rmj_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        ovf,
  output logic [31:0] quo
);

  logic [63:0] rem_q [rmj_pkg::DivSteps+1];
  logic [63:0] den_q [rmj_pkg::DivSteps+1];
  logic [31:0] quo_q [rmj_pkg::DivSteps+1];
  logic        ovf_q [rmj_pkg::DivSteps+1];

  // quotient does not fit 32 bits (or divide by zero with a nonzero numerator)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= num;
      den_q[0] <= den;
      quo_q[0] <= '0;
      ovf_q[0] <= ({32'd0, num} >= {den, 32'd0}) && (num != 64'd0);
    end
  end

  for (genvar j = 0; j < rmj_pkg::DivSteps; j++) begin : g_step
    logic [95:0] sh;
    logic [63:0] nrem;
    logic [31:0] nquo;

    // zero over zero keeps a zero quotient
    always_comb begin
      sh = {32'd0, den_q[j]} << (rmj_pkg::DivSteps - 1 - j);
      if ((den_q[j] != 64'd0) && ({32'd0, rem_q[j]} >= sh)) begin
        nrem = rem_q[j] - sh[63:0];
        nquo = quo_q[j] | (32'd1 << (rmj_pkg::DivSteps - 1 - j));
      end else begin
        nrem = rem_q[j];
        nquo = quo_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1] <= nrem;
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= nquo;
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign ovf = ovf_q[rmj_pkg::DivSteps];
  assign quo = quo_q[rmj_pkg::DivSteps];

endmodule

// ===== src/radar_measurement_jacobian.sv =====
`timescale 1ns / 1ps
// Radar measurement Jacobian for one constant-velocity state per beat.
// Input beat (s_*): s_tdata holds pos_x, pos_y, vel_x, vel_y, signed Q16.16.
// Output beat (m_*): m_tdata holds range_dx, range_dy, bearing_dx, bearing_dy,
// rate_dx, rate_dy (signed Q16.16, saturated); m_tuser[0] is the clamp flag.
// Config (cfg_*): index 0 near_zero_threshold, 1 near_zero_floor, 16-bit data;
// cfg_ready is always high, other indexes are dropped. Write only while idle.
// Throughput: one beat per cycle while s_tready is high. From input acceptance to
// m_tvalid a beat passes 3 front stages (magnitudes, products, sum and clamp), 32
// square root stages, 33 divider stages, 3 back stages (saturate, multiply,
// saturate) and the output register.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults 7 and 66.
// When m_tready is low, a skid register catches the beat in flight; while it
// is full s_tready drops and the whole pipeline holds, losing nothing.
`include "radar_measurement_jacobian_macros.svh"

module radar_measurement_jacobian (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy
  output logic [0:0]   m_tuser,   // clamped
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] thr, flr;
  logic        en;

  // output buffer
  logic            out_v, skid_v;
  rmj_pkg::beat_t  out_d, skid_d;

  assign en        = !skid_v;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rmj_pkg::ThresholdReset;
      flr <= rmj_pkg::FloorReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rmj_pkg::RegThreshold: thr <= cfg_data;
        rmj_pkg::RegFloor:     flr <= cfg_data;
        default: ;
      endcase
    end
  end

  // F0: sign and magnitude
  logic        f0_v;
  logic [31:0] f0_mx, f0_my, f0_mvx, f0_mvy;
  logic        f0_nx, f0_ny, f0_nvx, f0_nvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
    end else if (en) begin
      f0_v <= s_tvalid;
    end
    if (en) begin
      f0_mx  <= rmj_pkg::mag32(s_tdata[31:0]);
      f0_my  <= rmj_pkg::mag32(s_tdata[63:32]);
      f0_mvx <= rmj_pkg::mag32(s_tdata[95:64]);
      f0_mvy <= rmj_pkg::mag32(s_tdata[127:96]);
      f0_nx  <= s_tdata[31];
      f0_ny  <= s_tdata[63];
      f0_nvx <= s_tdata[95];
      f0_nvy <= s_tdata[127];
    end
  end

  // F1: squares and cross products
  logic        f1_v;
  logic [63:0] f1_xx, f1_yy, f1_a, f1_b;
  logic [31:0] f1_mx, f1_my;
  logic        f1_nx, f1_ny, f1_an, f1_bn;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= f0_v;
    end
    if (en) begin
      f1_xx <= f0_mx * f0_mx;
      f1_yy <= f0_my * f0_my;
      f1_a  <= f0_mvx * f0_my;
      f1_b  <= f0_mvy * f0_mx;
      f1_mx <= f0_mx;
      f1_my <= f0_my;
      f1_nx <= f0_nx;
      f1_ny <= f0_ny;
      f1_an <= f0_nvx ^ f0_ny;
      f1_bn <= f0_nvy ^ f0_nx;
    end
  end

  // F2: squared range with near-zero clamp, signed cross term
  logic           f2_v;
  rmj_pkg::side_t f2_side, f2_next;
  logic [63:0]    sq_raw;

  always_comb begin
    sq_raw         = f1_xx + f1_yy;
    f2_next.mx     = f1_mx;
    f2_next.my     = f1_my;
    f2_next.nx     = f1_nx;
    f2_next.ny     = f1_ny;
    f2_next.clamp  = sq_raw[63:rmj_pkg::FracW] < {32'd0, thr};
    f2_next.sq     = f2_next.clamp ? {32'd0, flr, 16'd0} : sq_raw;
    if (f1_an != f1_bn) begin
      f2_next.md = f1_a + f1_b;
      f2_next.nd = f1_an;
    end else if (f1_a >= f1_b) begin
      f2_next.md = f1_a - f1_b;
      f2_next.nd = f1_an;
    end else begin
      f2_next.md = f1_b - f1_a;
      f2_next.nd = !f1_bn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
    if (en) begin
      f2_side <= f2_next;
    end
  end

  // range = floor(sqrt(sq))
  logic           sr_v;
  rmj_pkg::side_t sr_side;
  logic [31:0]    root;

  rmj_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f2_v),
    .in_side   (f2_side),
    .out_valid (sr_v),
    .out_side  (sr_side),
    .out_root  (root)
  );

  // five quotients in parallel
  logic        ov_rx, ov_ry, ov_by, ov_bx, ov_t;
  logic [31:0] q_rx, q_ry, q_by, q_bx, q_t;

  rmj_div u_div_rx (.clk(clk), .en(en),
    .num({16'd0, sr_side.mx, 16'd0}), .den({32'd0, root}), .ovf(ov_rx), .quo(q_rx));
  rmj_div u_div_ry (.clk(clk), .en(en),
    .num({16'd0, sr_side.my, 16'd0}), .den({32'd0, root}), .ovf(ov_ry), .quo(q_ry));
  rmj_div u_div_by (.clk(clk), .en(en),
    .num({sr_side.my, 32'd0}), .den(sr_side.sq), .ovf(ov_by), .quo(q_by));
  rmj_div u_div_bx (.clk(clk), .en(en),
    .num({sr_side.mx, 32'd0}), .den(sr_side.sq), .ovf(ov_bx), .quo(q_bx));
  rmj_div u_div_t (.clk(clk), .en(en),
    .num(sr_side.md), .den({32'd0, root}), .ovf(ov_t), .quo(q_t));

  // signs and valid alongside the dividers
  rmj_pkg::tail_t tl [rmj_pkg::DivSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= rmj_pkg::DivSteps; i++) begin
        tl[i] <= '0;
      end
    end else if (en) begin
      tl[0] <= '{valid: sr_v, nx: sr_side.nx, ny: sr_side.ny,
                 nd: sr_side.nd, clamp: sr_side.clamp};
      for (int i = 1; i <= rmj_pkg::DivSteps; i++) begin
        tl[i] <= tl[i-1];
      end
    end
  end

  rmj_pkg::tail_t dt;
  assign dt = tl[rmj_pkg::DivSteps];

  // B1: saturate quotients
  logic        b1_v, b1_clamp, b1_n4, b1_n5;
  logic [31:0] b1_rdx, b1_rdy, b1_bdx, b1_bdy, b1_ym, b1_xm, b1_tm;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= dt.valid;
    end
    if (en) begin
      b1_rdx <= rmj_pkg::to_bits(dt.nx,
                  rmj_pkg::clamp_mag(dt.nx, rmj_pkg::div_mag(ov_rx, q_rx)));
      b1_rdy <= rmj_pkg::to_bits(dt.ny,
                  rmj_pkg::clamp_mag(dt.ny, rmj_pkg::div_mag(ov_ry, q_ry)));
      b1_bdx <= rmj_pkg::to_bits(!dt.ny,
                  rmj_pkg::clamp_mag(!dt.ny, rmj_pkg::div_mag(ov_by, q_by)));
      b1_bdy <= rmj_pkg::to_bits(dt.nx,
                  rmj_pkg::clamp_mag(dt.nx, rmj_pkg::div_mag(ov_bx, q_bx)));
      b1_ym  <= rmj_pkg::clamp_mag(dt.ny, rmj_pkg::div_mag(ov_by, q_by));
      b1_xm  <= rmj_pkg::clamp_mag(dt.nx, rmj_pkg::div_mag(ov_bx, q_bx));
      b1_tm  <= rmj_pkg::clamp_mag(dt.nd, rmj_pkg::div_mag(ov_t, q_t));
      b1_n4  <= dt.ny ^ dt.nd;
      b1_n5  <= dt.nx ^ !dt.nd;
      b1_clamp <= dt.clamp;
    end
  end

  // B2: rate products
  logic         b2_v, b2_clamp, b2_n4, b2_n5;
  logic [63:0]  b2_p4, b2_p5;
  logic [127:0] b2_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (en) begin
      b2_v <= b1_v;
    end
    if (en) begin
      b2_p4    <= b1_ym * b1_tm;
      b2_p5    <= b1_xm * b1_tm;
      b2_n4    <= b1_n4;
      b2_n5    <= b1_n5;
      b2_clamp <= b1_clamp;
      b2_lo    <= {b1_bdy, b1_bdx, b1_rdy, b1_rdx};
    end
  end

  // B3: scale and saturate rate terms
  logic           b3_v;
  rmj_pkg::beat_t b3_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (en) begin
      b3_v <= b2_v;
    end
    if (en) begin
      b3_d.data <= {
        rmj_pkg::to_bits(b2_n5, rmj_pkg::clamp_mag(b2_n5, b2_p5 >> rmj_pkg::FracW)),
        rmj_pkg::to_bits(b2_n4, rmj_pkg::clamp_mag(b2_n4, b2_p4 >> rmj_pkg::FracW)),
        b2_lo};
      b3_d.clamp <= b2_clamp;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (m_tready) begin
        skid_v <= 1'b0;
      end
    end else if (b3_v) begin
      if (out_v && !m_tready) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (m_tready) begin
        out_d <= skid_d;
      end
    end else if (b3_v) begin
      if (out_v && !m_tready) begin
        skid_d <= b3_d;
      end else begin
        out_d <= b3_d;
      end
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = out_d.data;
  assign m_tuser[0] = out_d.clamp;

  `RMJ_ASSERT_IMPL(a_skid_needs_out, skid_v, out_v)
  `RMJ_ASSERT_NEXT(a_skid_drains, skid_v && m_tready, !skid_v)
  `RMJ_ASSERT_NEXT(a_stall_holds_tail, !en, $stable(b3_v))
  `RMJ_ASSERT_NEXT(a_blocked_beat_caught, b3_v && en && out_v && !m_tready, skid_v)

endmodule
